[hdl/cubic_bezier_point_eval_macros.svh]
// assertion macros shared by the curve evaluator modules
// no dependencies; the empty forms are used when SYNTHESIS is defined
`ifndef CUBIC_BEZIER_POINT_EVAL_MACROS_SVH
`define CUBIC_BEZIER_POINT_EVAL_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define CBPE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CBPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CBPE_ASSERT(label, clk, rst, prop, msg)
`define CBPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[hdl/cbpe_pkg.sv]
// constants, widths and types of the cubic curve point evaluator
// no dependencies
package cbpe_pkg;

  localparam int STEPS   = 100;
  localparam int COORD_W = 16;
  localparam int IDX_W   = 7;
  localparam int LANES   = 2;

  localparam int STEP_W = $clog2(STEPS + 1);

  // denominator of the exact form: STEPS cubed
  localparam longint DEN   = longint'(STEPS) * STEPS * STEPS;
  localparam int     DEN_W = $clog2(DEN + 1);

  // weighted sums stay inside the hull, so magnitude is at most 2^15 * DEN
  localparam int NUM_W = DEN_W + COORD_W;
  localparam int MAG_W = NUM_W - 1;

  // reciprocal divide: upper bits of magnitude times scaled 1/DEN
  localparam int     HI_W      = (MAG_W < 30) ? MAG_W : 30;
  localparam int     DIV_SHIFT = MAG_W - HI_W;
  localparam int     QK        = HI_W + 2;
  localparam longint RECIP     = (longint'(1) << (QK + DIV_SHIFT)) / DEN;
  localparam int     RECIP_W   = $clog2(RECIP + 1);
  localparam int     PRD_W     = HI_W + RECIP_W;
  localparam int     Q_W       = COORD_W;
  localparam int     REM_W     = DEN_W + 1;

  localparam logic [STEP_W-1:0]  STEPS_V = STEP_W'(STEPS);
  localparam logic [DEN_W-1:0]   DEN_V   = DEN_W'(DEN);
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

  typedef logic [STEP_W-1:0]         step_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [DEN_W-1:0] w0;
    logic [DEN_W-1:0] w1;
    logic [DEN_W-1:0] w2;
    logic [DEN_W-1:0] w3;
  } wgt_t;

  typedef struct packed {
    coord_t p0;
    coord_t p1;
    coord_t p2;
    coord_t p3;
  } ctrl_pts_t;

endpackage

[hdl/cubic_bezier_point_eval.sv]
// Cubic Bezier point evaluator. Each request carries the four control points and a step
// index i; the result is the curve point at t = i/STEPS (STEPS = 100), computed exactly as
// the Bernstein-weighted sum divided by STEPS^3 and truncated toward zero; an index above
// STEPS gives the finish point. One request is taken every clock while no result waits at the
// output; a request passes 3 stages that form the weights, 4 that form the weighted sum and its
// magnitude, and 3 that divide by STEPS^3 with a reciprocal multiply and one correction step.
// The whole pipeline holds while a result waits, so req_ready follows res_ready directly.
// Depends on cbpe_pkg, cbpe_weights, cbpe_dot and cbpe_div.
module cubic_bezier_point_eval (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic signed [15:0]            start_x,
  input  logic signed [15:0]            start_y,
  input  logic signed [15:0]            ctrl1_x,
  input  logic signed [15:0]            ctrl1_y,
  input  logic signed [15:0]            ctrl2_x,
  input  logic signed [15:0]            ctrl2_y,
  input  logic signed [15:0]            finish_x,
  input  logic signed [15:0]            finish_y,
  input  logic [cbpe_pkg::IDX_W-1:0]    step_index,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic signed [15:0]            point_x,
  output logic signed [15:0]            point_y
);
  import cbpe_pkg::*;

  logic       adv;
  logic       w_valid, d_valid;
  wgt_t       wgt;
  ctrl_pts_t  pts [LANES];
  logic       neg [LANES];
  logic [MAG_W-1:0] mag [LANES];
  coord_t     quot [LANES];

  // pipeline moves unless the output holds a result not yet taken
  assign adv       = !res_valid || res_ready;
  assign req_ready = adv;

  assign pts[0] = '{p0: start_x, p1: ctrl1_x, p2: ctrl2_x, p3: finish_x};
  assign pts[1] = '{p0: start_y, p1: ctrl1_y, p2: ctrl2_y, p3: finish_y};

  cbpe_weights u_weights (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (req_valid),
    .step_index (step_index),
    .out_valid  (w_valid),
    .wgt        (wgt)
  );

  cbpe_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .pts       (pts),
    .in_valid  (w_valid),
    .wgt       (wgt),
    .out_valid (d_valid),
    .neg       (neg),
    .mag       (mag)
  );

  cbpe_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .neg       (neg),
    .mag       (mag),
    .out_valid (res_valid),
    .quot      (quot)
  );

  assign point_x = quot[0];
  assign point_y = quot[1];

endmodule

[hdl/cbpe_weights.sv]
// stages 1 to 3: step index to the four Bernstein weights scaled by STEPS^3
// depends on cbpe_pkg and the assertion macro header
`include "cubic_bezier_point_eval_macros.svh"

module cbpe_weights (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [cbpe_pkg::IDX_W-1:0]     step_index,
  output logic                           out_valid,
  output cbpe_pkg::wgt_t                 wgt
);
  import cbpe_pkg::*;

  localparam int SQ_W   = 2 * STEP_W;
  localparam int CUBE_W = 3 * STEP_W + 2;

  logic            v1, v2;
  step_t           idx_sat;
  step_t           i1, u1, i2, u2;
  logic [SQ_W-1:0] uu2, ii2, ui2;
  logic [CUBE_W-1:0] c0, c1, c2, c3;

  // index beyond STEPS lands on the finish point
  assign idx_sat = (int'(step_index) > STEPS) ? STEPS_V : STEP_W'(step_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  assign c0 = CUBE_W'(uu2) * CUBE_W'(u2);
  assign c1 = CUBE_W'(uu2) * CUBE_W'(i2) * CUBE_W'(2'd3);
  assign c2 = CUBE_W'(ui2) * CUBE_W'(i2) * CUBE_W'(2'd3);
  assign c3 = CUBE_W'(ii2) * CUBE_W'(i2);

  always_ff @(posedge clk) begin
    if (adv) begin
      i1     <= idx_sat;
      u1     <= STEPS_V - idx_sat;
      i2     <= i1;
      u2     <= u1;
      uu2    <= SQ_W'(u1) * SQ_W'(u1);
      ii2    <= SQ_W'(i1) * SQ_W'(i1);
      ui2    <= SQ_W'(u1) * SQ_W'(i1);
      wgt.w0 <= c0[DEN_W-1:0];
      wgt.w1 <= c1[DEN_W-1:0];
      wgt.w2 <= c2[DEN_W-1:0];
      wgt.w3 <= c3[DEN_W-1:0];
    end
  end

  `CBPE_ASSERT(a_wgt_sum, clk, rst, !out_valid || ((DEN_W+2)'(wgt.w0) + (DEN_W+2)'(wgt.w1) + (DEN_W+2)'(wgt.w2) + (DEN_W+2)'(wgt.w3) == (DEN_W+2)'(DEN_V)), "weights do not sum to STEPS cubed")

endmodule

[hdl/cbpe_dot.sv]
// stages 4 to 7: weighted sum of the control points per axis, then sign and magnitude
// depends on cbpe_pkg and the assertion macro header
`include "cubic_bezier_point_eval_macros.svh"

module cbpe_dot (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  cbpe_pkg::ctrl_pts_t         pts [cbpe_pkg::LANES],
  input  logic                        in_valid,
  input  cbpe_pkg::wgt_t              wgt,
  output logic                        out_valid,
  output logic                        neg [cbpe_pkg::LANES],
  output logic [cbpe_pkg::MAG_W-1:0]  mag [cbpe_pkg::LANES]
);
  import cbpe_pkg::*;

  localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'(DEN << (COORD_W - 1));

  logic v4, v5, v6;

  // points wait here while the weights are formed
  ctrl_pts_t pts1 [LANES];
  ctrl_pts_t pts2 [LANES];
  ctrl_pts_t pts3 [LANES];

  logic signed [NUM_W-1:0] prod [LANES][4];
  logic signed [NUM_W-1:0] s01 [LANES];
  logic signed [NUM_W-1:0] s23 [LANES];
  logic signed [NUM_W-1:0] num [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v4        <= in_valid;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        pts1[l]    <= pts[l];
        pts2[l]    <= pts1[l];
        pts3[l]    <= pts2[l];
        prod[l][0] <= NUM_W'($signed({1'b0, wgt.w0})) * NUM_W'(pts3[l].p0);
        prod[l][1] <= NUM_W'($signed({1'b0, wgt.w1})) * NUM_W'(pts3[l].p1);
        prod[l][2] <= NUM_W'($signed({1'b0, wgt.w2})) * NUM_W'(pts3[l].p2);
        prod[l][3] <= NUM_W'($signed({1'b0, wgt.w3})) * NUM_W'(pts3[l].p3);
        s01[l]     <= prod[l][0] + prod[l][1];
        s23[l]     <= prod[l][2] + prod[l][3];
        num[l]     <= s01[l] + s23[l];
        neg[l]     <= num[l][NUM_W-1];
        mag[l]     <= num[l][NUM_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
      end
    end
  end

  `CBPE_ASSERT(a_mag_x, clk, rst, !out_valid || (mag[0] <= MAG_LIM), "x magnitude outside hull")
  `CBPE_ASSERT(a_mag_y, clk, rst, !out_valid || (mag[1] <= MAG_LIM), "y magnitude outside hull")

endmodule

[hdl/cbpe_div.sv]
// stages 8 to 10: divide the magnitude by STEPS^3 through a reciprocal, correct, re-sign
// depends on cbpe_pkg and the assertion macro header
`include "cubic_bezier_point_eval_macros.svh"

module cbpe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic                        neg [cbpe_pkg::LANES],
  input  logic [cbpe_pkg::MAG_W-1:0]  mag [cbpe_pkg::LANES],
  output logic                        out_valid,
  output cbpe_pkg::coord_t            quot [cbpe_pkg::LANES]
);
  import cbpe_pkg::*;

  localparam logic [REM_W-1:0] REM_LIM = REM_W'(2 * DEN);

  logic v8, v9;

  logic [PRD_W-1:0] prod8 [LANES];
  logic [MAG_W-1:0] mag8  [LANES];
  logic             neg8  [LANES];
  logic [Q_W-1:0]   qe9   [LANES];
  logic [REM_W-1:0] rem9  [LANES];
  logic             neg9  [LANES];
  logic [Q_W-1:0]   q_fix [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8        <= 1'b0;
      v9        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v8        <= in_valid;
      v9        <= v8;
      out_valid <= v9;
    end
  end

  // estimate is the true quotient or one below it
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_fix[l] = qe9[l] + Q_W'(rem9[l] >= REM_W'(DEN_V));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        prod8[l] <= PRD_W'(mag[l][MAG_W-1 -: HI_W]) * PRD_W'(RECIP_V);
        mag8[l]  <= mag[l];
        neg8[l]  <= neg[l];
        qe9[l]   <= prod8[l][QK +: Q_W];
        rem9[l]  <= REM_W'(mag8[l] - MAG_W'(prod8[l][QK +: Q_W]) * MAG_W'(DEN_V));
        neg9[l]  <= neg8[l];
        quot[l]  <= neg9[l] ? COORD_W'(-q_fix[l]) : COORD_W'(q_fix[l]);
      end
    end
  end

  `CBPE_ASSERT(a_rem_x, clk, rst, !v9 || (rem9[0] < REM_LIM), "x quotient estimate off by more than one")
  `CBPE_ASSERT(a_rem_y, clk, rst, !v9 || (rem9[1] < REM_LIM), "y quotient estimate off by more than one")

endmodule

[tb/cubic_bezier_point_eval_tb.sv]
// self-checking testbench for the cubic curve point evaluator
// depends on cbpe_pkg and cubic_bezier_point_eval; predicts each point with exact integer math
`timescale 1ns / 100ps

module cubic_bezier_point_eval_tb;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int IDLE_PCT        = 36;

  typedef logic signed [15:0] coord_t;
  typedef logic [cbpe_pkg::IDX_W-1:0] idx_t;

  typedef struct {
    coord_t sx, sy, c1x, c1y, c2x, c2y, fx, fy;
    logic [cbpe_pkg::IDX_W-1:0] idx;
  } curve_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  coord_t start_x = '0, start_y = '0;
  coord_t ctrl1_x = '0, ctrl1_y = '0;
  coord_t ctrl2_x = '0, ctrl2_y = '0;
  coord_t finish_x = '0, finish_y = '0;
  logic [cbpe_pkg::IDX_W-1:0] step_index = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  coord_t point_x, point_y;

  curve_point_t pending_points[$];
  int error_count = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_off_pending = 1'b0;

  cubic_bezier_point_eval i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .start_x    (start_x),
    .start_y    (start_y),
    .ctrl1_x    (ctrl1_x),
    .ctrl1_y    (ctrl1_y),
    .ctrl2_x    (ctrl2_x),
    .ctrl2_y    (ctrl2_y),
    .finish_x   (finish_x),
    .finish_y   (finish_y),
    .step_index (step_index),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .point_x    (point_x),
    .point_y    (point_y)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bernstein-weighted sum over STEPS^3, truncated toward zero
  function automatic coord_t bezier_axis(longint p0, longint p1, longint p2, longint p3,
                                         longint i);
    longint n;
    longint u;
    longint num;
    n = longint'(cbpe_pkg::STEPS);
    if (i > n) i = n;
    u = n - i;
    num = u * u * u * p0 + 3 * u * u * i * p1 + 3 * u * i * i * p2 + i * i * i * p3;
    return coord_t'(num / (n * n * n));
  endfunction

  function automatic curve_point_t eval_curve_point(curve_req_t r);
    curve_point_t p;
    p.x = bezier_axis(longint'(r.sx), longint'(r.c1x), longint'(r.c2x), longint'(r.fx),
                      longint'(r.idx));
    p.y = bezier_axis(longint'(r.sy), longint'(r.c1y), longint'(r.c2y), longint'(r.fy),
                      longint'(r.idx));
    return p;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(int'($urandom_range(8)) - 4);
      default: return coord_t'($urandom_range(65535));
    endcase
  endfunction

  function automatic curve_req_t rand_curve();
    curve_req_t r;
    r.sx = rand_coord();
    r.sy = rand_coord();
    r.c1x = rand_coord();
    r.c1y = rand_coord();
    r.c2x = rand_coord();
    r.c2y = rand_coord();
    r.fx = rand_coord();
    r.fy = rand_coord();
    // mostly in range, some beyond STEPS to hit saturation
    if ($urandom_range(9) == 0) r.idx = idx_t'($urandom_range(127, cbpe_pkg::STEPS + 1));
    else r.idx = idx_t'($urandom_range(cbpe_pkg::STEPS));
    return r;
  endfunction

  function automatic curve_req_t make_curve(coord_t v0, coord_t v1, coord_t v2, coord_t v3,
                                            int idx);
    curve_req_t r;
    r.sx = v0;
    r.c1x = v1;
    r.c2x = v2;
    r.fx = v3;
    r.sy = -v3 - 16'sd1;
    r.c1y = -v2 - 16'sd1;
    r.c2y = -v1 - 16'sd1;
    r.fy = -v0 - 16'sd1;
    r.idx = idx_t'(idx);
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_curve(curve_req_t r);
    int gap;
    gap = 0;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    start_x <= r.sx;
    start_y <= r.sy;
    ctrl1_x <= r.c1x;
    ctrl1_y <= r.c1y;
    ctrl2_x <= r.c2x;
    ctrl2_y <= r.c2y;
    finish_x <= r.fx;
    finish_y <= r.fy;
    step_index <= r.idx;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic test_endpoints();
    curve_req_t r;
    r = rand_curve();
    r.idx = 0;
    send_curve(r);
    r.idx = idx_t'(cbpe_pkg::STEPS);
    send_curve(r);
    r.idx = idx_t'(cbpe_pkg::STEPS + 1);
    send_curve(r);
    r.idx = 127;
    send_curve(r);
    r.idx = 1;
    send_curve(r);
    r.idx = idx_t'(cbpe_pkg::STEPS - 1);
    send_curve(r);
    r.idx = 64;
    send_curve(r);
  endtask

  task automatic test_extremes();
    send_curve(make_curve(-32768, -32768, -32768, -32768, 50));
    send_curve(make_curve(32767, 32767, 32767, 32767, 50));
    send_curve(make_curve(-32768, 32767, 32767, -32768, 50));
    send_curve(make_curve(32767, -32768, -32768, 32767, 50));
    send_curve(make_curve(-32768, 32767, -32768, 32767, 37));
    send_curve(make_curve(32767, -32768, 32767, -32768, 63));
    send_curve(make_curve(-32768, -32768, -32768, -32768, 127));
    send_curve(make_curve(32767, 32767, 32767, 32767, 0));
  endtask

  // small sums where truncation toward zero differs from floor
  task automatic test_truncation();
    send_curve(make_curve(0, 0, 0, -1, 1));
    send_curve(make_curve(0, 0, 0, 1, 1));
    send_curve(make_curve(-1, -1, -1, 0, 99));
    send_curve(make_curve(0, -3, 3, 0, 33));
    send_curve(make_curve(5, -7, 2, -3, 71));
    send_curve(make_curve(0, 0, -1, -1, 50));
  endtask

  task automatic test_random_points(int count);
    repeat (count) send_curve(rand_curve());
  endtask

  task automatic test_full_rate(int count);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (count) send_curve(rand_curve());
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // receiver holds off while requests keep coming, so the pipeline backs up
  task automatic test_output_hold_off(int count);
    hold_off_pending = 1'b1;
    repeat (count) send_curve(rand_curve());
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ready <= 1'b0;
      end else if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        res_ready <= !stalls_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    curve_req_t r;
    curve_point_t exp_pt;
    if (!rst) begin
      if (req_valid && req_ready) begin
        r.sx = start_x;
        r.sy = start_y;
        r.c1x = ctrl1_x;
        r.c1y = ctrl1_y;
        r.c2x = ctrl2_x;
        r.c2y = ctrl2_y;
        r.fx = finish_x;
        r.fy = finish_y;
        r.idx = step_index;
        pending_points.push_back(eval_curve_point(r));
      end
      if (res_valid && res_ready) begin
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected result x %0d y %0d", $time, point_x, point_y);
          error_count++;
        end else begin
          exp_pt = pending_points.pop_front();
          if (point_x !== exp_pt.x) begin
            $display("%0t: point_x expected %0d, got %0d", $time, exp_pt.x, point_x);
            error_count++;
          end
          if (point_y !== exp_pt.y) begin
            $display("%0t: point_y expected %0d, got %0d", $time, exp_pt.y, point_y);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (res_valid && res_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[cubic_bezier_point_eval] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_endpoints();
    test_extremes();
    test_truncation();
    test_random_points(500);
    test_full_rate(200);
    test_output_hold_off(80);
    test_random_points(200);
    req_valid <= 1'b0;
    while (pending_points.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[cubic_bezier_point_eval] OK");
    end else begin
      $display("[cubic_bezier_point_eval] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/cbpe_pkg.sv
hdl/cbpe_weights.sv
hdl/cbpe_dot.sv
hdl/cbpe_div.sv
hdl/cubic_bezier_point_eval.sv
tb/cubic_bezier_point_eval_tb.sv
